>>> hdl/bds_pkg.sv
// Package for the bitset domain store: sizes, command codes and bit-scan helpers.
// No dependencies.
package bds_pkg;
  localparam int NumVars     = 64;
  localparam int WordBits    = 64;
  localparam int MaxDomain   = 256;
  localparam int WordsPerVar = (MaxDomain + WordBits - 1) / WordBits;
  localparam int VarW        = 6;
  localparam int WidxW       = 2;
  localparam int MemDepth    = NumVars * WordsPerVar;
  localparam int MemAw       = VarW + WidxW;
  localparam int BitW        = 6;

  localparam logic [2:0] CmdInit    = 3'd0;
  localparam logic [2:0] CmdRemove  = 3'd1;
  localparam logic [2:0] CmdAdd     = 3'd2;
  localparam logic [2:0] CmdReduce  = 3'd3;
  localparam logic [2:0] CmdRestore = 3'd4;
  localparam logic [2:0] CmdQuery   = 3'd5;

  // Mask of the k lowest bits, k saturated at the word width.
  function automatic logic [WordBits-1:0] low_mask(input logic [9:0] k);
    logic [WordBits-1:0] m;
    m = '0;
    for (int i = 0; i < WordBits; i++) begin
      m[i] = (10'(i) < k);
    end
    return m;
  endfunction

  function automatic logic [BitW-1:0] lowest_bit(input logic [WordBits-1:0] x);
    logic [BitW-1:0] r;
    r = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (x[i]) r = BitW'(i);
    end
    return r;
  endfunction

  function automatic logic [BitW-1:0] highest_bit(input logic [WordBits-1:0] x);
    logic [BitW-1:0] r;
    r = '0;
    for (int i = 0; i < WordBits; i++) begin
      if (x[i]) r = BitW'(i);
    end
    return r;
  endfunction

  function automatic logic [6:0] popcount(input logic [WordBits-1:0] x);
    logic [6:0] c;
    c = '0;
    for (int i = 0; i < WordBits; i++) begin
      c = c + 7'(x[i]);
    end
    return c;
  endfunction
endpackage

>>> hdl/bds_ram.sv
// Generic single-port RAM with a registered read.
// No dependencies.
module bds_ram #(
  parameter int Width = 64,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> hdl/bitset_domain_store.sv
// Bitset domain store top level: sequencer around the domain word memory and the count memory.
// Depends on bds_pkg and bds_ram.
//
// A request is accepted when start is high and busy is low. Busy then stays high and falls in
// the cycle of the status strobe. The sequencer walks the four domain words of the variable
// twice through one single-port word memory. The first pass reads, modifies and writes back
// each word, in a read state and a modify state. The second pass is a scan for presence, next,
// head and tail: a read state, a scan state that scans each word while the next is read, and a
// done state. The value count and the assigned flag sit in a second memory that is read at the
// variable during the first pass and written once at its end. After reset a clearing pass over
// all 256 addresses zeroes both memories while busy stays high. Trail records come out during
// the first pass, each a one-cycle strobe with last low, and the status result follows with
// last high; the receiver cannot stall.
module bitset_domain_store
  import bds_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic [2:0]  cmd_i,
  input  logic [5:0]  var_id_i,
  input  logic [8:0]  value_i,
  input  logic [1:0]  word_index_i,
  input  logic [63:0] word_data_i,
  output logic        valid_o,
  output logic [1:0]  trail_word_index_o,
  output logic [63:0] trail_old_word_o,
  output logic [8:0]  value_count_o,
  output logic        is_assigned_o,
  output logic        has_value_o,
  output logic [7:0]  succ_value_o,
  output logic        found_next_o,
  output logic [7:0]  head_value_o,
  output logic [7:0]  tail_value_o,
  output logic        nonempty_o,
  output logic        last_o
);
  typedef enum logic [2:0] {
    StClear, StIdle, StRd1, StMod, StRd2, StScan, StDone
  } state_e;

  state_e            state_q;
  logic [MemAw-1:0]  clr_q;
  logic [WidxW:0]    w_q;
  logic              trail_en_q;
  logic [2:0]        cmd_q;
  logic [VarW-1:0]   var_q;
  logic [8:0]        val_q;
  logic [WidxW-1:0]  widx_q;
  logic [WordBits-1:0] wdata_q;
  logic [8:0]        pop_q;
  logic              has_q, fn_q, ne_q;
  logic [7:0]        next_q, head_q, tail_q;

  logic                mem_we;
  logic [MemAw-1:0]    mem_addr;
  logic [WordBits-1:0] mem_wdata, mem_rdata;

  logic                cnt_we;
  logic [VarW-1:0]     cnt_addr;
  logic [9:0]          cnt_wdata, cnt_rdata;

  bds_ram #(.Width(WordBits), .Depth(MemDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  // Each entry holds the assigned flag above the 9-bit value count.
  bds_ram #(.Width(10), .Depth(NumVars)) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .addr_i (cnt_addr),
    .wdata_i(cnt_wdata),
    .rdata_o(cnt_rdata)
  );

  logic [WidxW-1:0] wi;
  logic [WidxW-1:0] sw;
  logic             in_range;
  logic [WidxW-1:0] vword;
  logic [BitW-1:0]  vbit;
  logic [WordBits-1:0] new_word;
  logic             changes;
  logic [9:0]       n_sat, nrel;
  logic [WordBits-1:0] scan_mask, scan_bits;
  logic [9:0]       nxt_start;
  logic [8:0]       pop_sum;
  logic [8:0]       cnt_new;
  logic             asg_new;

  assign wi       = w_q[WidxW-1:0];
  assign sw       = WidxW'(w_q - 1'b1);
  assign in_range = (val_q < 9'(MaxDomain));
  assign vword    = val_q[BitW+WidxW-1:BitW];
  assign vbit     = val_q[BitW-1:0];
  assign n_sat    = (val_q > 9'(MaxDomain)) ? 10'(MaxDomain) : {1'b0, val_q};
  assign nrel     = (n_sat > {2'b0, wi, 6'd0}) ? n_sat - {2'b0, wi, 6'd0} : 10'd0;
  assign nxt_start = {1'b0, val_q} + 10'd1;
  assign pop_sum  = pop_q + 9'(popcount(new_word));

  // New word contents and whether the word is written, in the modify cycle.
  always_comb begin
    new_word = mem_rdata;
    changes  = 1'b0;
    case (cmd_q)
      CmdInit: begin
        new_word = low_mask(nrel);
        changes  = 1'b1;
      end
      CmdRemove, CmdAdd: begin
        if (in_range && wi == vword) begin
          changes = 1'b1;
          if (cmd_q == CmdRemove) new_word[vbit] = 1'b0;
          else new_word[vbit] = 1'b1;
        end
      end
      CmdReduce: begin
        if (in_range) begin
          changes  = 1'b1;
          new_word = '0;
          if (wi == vword) new_word[vbit] = 1'b1;
        end
      end
      CmdRestore: begin
        if (wi == widx_q) begin
          changes  = 1'b1;
          new_word = wdata_q & low_mask(10'(MaxDomain) - {2'b0, wi, 6'd0});
        end
      end
      default: ;
    endcase
  end

  // Count and assigned flag written back at the end of the modify pass.
  always_comb begin
    cnt_new = cnt_rdata[8:0];
    asg_new = cnt_rdata[9];
    case (cmd_q)
      CmdInit: begin
        cnt_new = n_sat[8:0];
        asg_new = 1'b0;
      end
      CmdRemove: begin
        if (in_range && cnt_rdata[8:0] != '0) cnt_new = cnt_rdata[8:0] - 9'd1;
      end
      CmdAdd: begin
        if (in_range && cnt_rdata[8:0] != 9'(MaxDomain)) cnt_new = cnt_rdata[8:0] + 9'd1;
      end
      CmdReduce: begin
        if (in_range) begin
          cnt_new = 9'd1;
          asg_new = 1'b1;
        end
      end
      CmdRestore: begin
        cnt_new = pop_sum;
        asg_new = (pop_sum == 9'd1);
      end
      default: ;
    endcase
  end

  // Bits at or above value+1 for the next-value scan; sw is the word now on mem_rdata.
  always_comb begin
    scan_mask = '1;
    if (nxt_start[9:8] != 2'd0) scan_mask = '0;
    else if (sw < nxt_start[7:6]) scan_mask = '0;
    else if (sw == nxt_start[7:6]) scan_mask = ~low_mask({4'd0, nxt_start[5:0]});
    scan_bits = mem_rdata & scan_mask;
  end

  always_comb begin
    mem_we    = (state_q == StClear) || (state_q == StMod && changes);
    mem_wdata = (state_q == StClear) ? '0 : new_word;
    if (state_q == StClear) mem_addr = clr_q;
    else mem_addr = {var_q, wi};
  end

  always_comb begin
    cnt_we    = (state_q == StClear) ||
                (state_q == StMod && wi == WidxW'(WordsPerVar - 1));
    cnt_wdata = (state_q == StClear) ? '0 : {asg_new, cnt_new};
    cnt_addr  = (state_q == StClear) ? clr_q[VarW-1:0] : var_q;
  end

  assign busy_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      clr_q      <= '0;
      w_q        <= '0;
      trail_en_q <= 1'b1;
      valid_o    <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      if (cfg_we_i) trail_en_q <= cfg_wdata_i;
      case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == MemAw'(MemDepth - 1)) state_q <= StIdle;
        end
        StIdle: begin
          if (start_i) begin
            cmd_q   <= (cmd_i > CmdQuery) ? CmdQuery : cmd_i;
            var_q   <= var_id_i;
            val_q   <= value_i;
            widx_q  <= word_index_i;
            wdata_q <= word_data_i;
            w_q     <= '0;
            pop_q   <= '0;
            state_q <= StRd1;
          end
        end
        StRd1: state_q <= StMod;
        StMod: begin
          // Trail the old word before it changes.
          if (trail_en_q && in_range && mem_rdata != '0 &&
              ((cmd_q == CmdReduce) ||
               ((cmd_q == CmdRemove || cmd_q == CmdAdd) && wi == vword))) begin
            valid_o            <= 1'b1;
            last_o             <= 1'b0;
            trail_word_index_o <= wi;
            trail_old_word_o   <= mem_rdata;
            value_count_o      <= '0;
            is_assigned_o      <= 1'b0;
            has_value_o        <= 1'b0;
            succ_value_o       <= '0;
            found_next_o       <= 1'b0;
            head_value_o       <= '0;
            tail_value_o       <= '0;
            nonempty_o         <= 1'b0;
          end
          if (trail_en_q && in_range && mem_rdata == '0 &&
              (cmd_q == CmdRemove || cmd_q == CmdAdd) && wi == vword) begin
            valid_o            <= 1'b1;
            last_o             <= 1'b0;
            trail_word_index_o <= wi;
            trail_old_word_o   <= '0;
            value_count_o      <= '0;
            is_assigned_o      <= 1'b0;
            has_value_o        <= 1'b0;
            succ_value_o       <= '0;
            found_next_o       <= 1'b0;
            head_value_o       <= '0;
            tail_value_o       <= '0;
            nonempty_o         <= 1'b0;
          end
          pop_q <= pop_sum;
          if (wi == WidxW'(WordsPerVar - 1)) begin
            w_q     <= '0;
            state_q <= StRd2;
          end else begin
            w_q     <= w_q + 1'b1;
            state_q <= StRd1;
          end
        end
        StRd2: begin
          has_q   <= 1'b0;
          fn_q    <= 1'b0;
          ne_q    <= 1'b0;
          next_q  <= '0;
          head_q  <= '0;
          tail_q  <= '0;
          state_q <= StScan;
          w_q     <= w_q + 1'b1;
        end
        StScan: begin
          // Read of word w_q is in flight; mem_rdata holds word w_q-1.
          if (in_range && vword == sw) has_q <= mem_rdata[vbit];
          if (!fn_q && scan_bits != '0) begin
            fn_q   <= 1'b1;
            next_q <= {sw, lowest_bit(scan_bits)};
          end
          if (mem_rdata != '0) begin
            if (!ne_q) head_q <= {sw, lowest_bit(mem_rdata)};
            ne_q   <= 1'b1;
            tail_q <= {sw, highest_bit(mem_rdata)};
          end
          if (w_q == (WidxW + 1)'(WordsPerVar)) state_q <= StDone;
          else w_q <= w_q + 1'b1;
        end
        StDone: begin
          valid_o            <= 1'b1;
          last_o             <= 1'b1;
          trail_word_index_o <= '0;
          trail_old_word_o   <= '0;
          value_count_o      <= cnt_rdata[8:0];
          is_assigned_o      <= cnt_rdata[9];
          has_value_o        <= has_q;
          succ_value_o       <= next_q;
          found_next_o       <= fn_q;
          head_value_o       <= head_q;
          tail_value_o       <= tail_q;
          nonempty_o         <= ne_q;
          state_q            <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !valid_o)
    else $error("status strobe longer than one cycle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == StClear || state_q == StMod))
    else $error("memory written outside clear or modify");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> busy_o)
    else $error("trail record after the request ended");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |=> valid_o && last_o && !busy_o)
    else $error("status result missing");
endmodule

>>> verif/tb_bitset_domain_store.sv
// Self-checking testbench for bitset_domain_store: directed table plus random requests.
// Every trail record and status result is checked against a predictor of the domain store.
// Depends on bds_pkg and the bitset_domain_store RTL.
`timescale 1ns / 100ps

module tb_bitset_domain_store
  import bds_pkg::*;
();

  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;
  localparam int unsigned CycleLimit = 200000;
  localparam int SettleCycles = 30;

  typedef struct packed {
    logic [1:0]  widx;
    logic [63:0] old_word;
    logic [8:0]  count;
    logic        assigned;
    logic        has;
    logic [7:0]  next;
    logic        found;
    logic [7:0]  head;
    logic [7:0]  tail;
    logic        nonempty;
    logic        last;
  } status_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [5:0]  var_id;
    logic [8:0]  value;
    logic [1:0]  widx;
    logic [63:0] wdata;
    bit          typed;     // count and assigned below replace the predicted values
    logic [8:0]  count;
    logic        assigned;
  } request_t;

  logic        clk, rst_n, start, busy, cfg_we, cfg_wdata;
  logic [2:0]  cmd;
  logic [5:0]  var_id;
  logic [8:0]  value;
  logic [1:0]  word_index;
  logic [63:0] word_data;
  logic        valid;
  status_t     got;

  bitset_domain_store i_dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .cmd_i(cmd), .var_id_i(var_id), .value_i(value), .word_index_i(word_index),
    .word_data_i(word_data), .valid_o(valid),
    .trail_word_index_o(got.widx), .trail_old_word_o(got.old_word),
    .value_count_o(got.count), .is_assigned_o(got.assigned), .has_value_o(got.has),
    .succ_value_o(got.next), .found_next_o(got.found), .head_value_o(got.head),
    .tail_value_o(got.tail), .nonempty_o(got.nonempty), .last_o(got.last)
  );

  // Predictor state: each domain as one 256-bit vector.
  logic [MaxDomain-1:0] domains [NumVars];
  logic [8:0]           counts  [NumVars];
  logic                 assigned_q [NumVars];
  logic                 trail_on;
  status_t              pending [$];
  int                   errors;
  int unsigned          cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout with %0d results outstanding", $time, pending.size());
      $display("bitset_domain_store regression: fail");
      $finish;
    end
  end

  task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    status_t e;
    if (rst_n && valid) begin
      if (pending.size() == 0) begin
        $display("%0t unexpected result: expected none actual %p", $time, got);
        errors++;
      end else begin
        e = pending.pop_front();
        check_field("trail_word_index", 64'(e.widx), 64'(got.widx));
        check_field("trail_old_word", e.old_word, got.old_word);
        check_field("value_count", 64'(e.count), 64'(got.count));
        check_field("is_assigned", 64'(e.assigned), 64'(got.assigned));
        check_field("has_value", 64'(e.has), 64'(got.has));
        check_field("succ_value", 64'(e.next), 64'(got.next));
        check_field("found_next", 64'(e.found), 64'(got.found));
        check_field("head_value", 64'(e.head), 64'(got.head));
        check_field("tail_value", 64'(e.tail), 64'(got.tail));
        check_field("nonempty", 64'(e.nonempty), 64'(got.nonempty));
        check_field("last", 64'(e.last), 64'(got.last));
      end
    end
  end

  function automatic void push_trail(int w, logic [63:0] old);
    status_t t;
    t = '0;
    t.widx = 2'(w);
    t.old_word = old;
    pending = {pending, t};
  endfunction

  // Applies one request to the predictor and queues the results it causes.
  function automatic void apply_request(request_t r);
    status_t s;
    logic [MaxDomain-1:0] d;
    int v, n, w;
    bit in_range;
    v = int'(r.var_id);
    in_range = r.value < MaxDomain;
    d = domains[v];
    case (r.cmd)
      CmdInit: begin
        n = (r.value > MaxDomain) ? MaxDomain : int'(r.value);
        d = '0;
        for (int i = 0; i < n; i++) d[i] = 1'b1;
        counts[v] = 9'(n);
        assigned_q[v] = 1'b0;
      end
      CmdRemove, CmdAdd: if (in_range) begin
        w = r.value / WordBits;
        if (trail_on) push_trail(w, d[w*WordBits +: WordBits]);
        if (r.cmd == CmdRemove) begin
          d[r.value] = 1'b0;
          if (counts[v] > 0) counts[v]--;
        end else begin
          d[r.value] = 1'b1;
          if (counts[v] < MaxDomain) counts[v]++;
        end
      end
      CmdReduce: if (in_range) begin
        for (int i = 0; i < WordsPerVar; i++)
          if (trail_on && d[i*WordBits +: WordBits] != '0)
            push_trail(i, d[i*WordBits +: WordBits]);
        d = '0;
        d[r.value] = 1'b1;
        counts[v] = 9'd1;
        assigned_q[v] = 1'b1;
      end
      CmdRestore: begin
        d[r.widx*WordBits +: WordBits] = r.wdata;
        counts[v] = 9'($countones(d));
        assigned_q[v] = (counts[v] == 9'd1);
      end
      default: ;
    endcase
    domains[v] = d;

    s = '0;
    s.count = counts[v];
    s.assigned = assigned_q[v];
    s.has = in_range ? d[r.value] : 1'b0;
    for (int i = MaxDomain - 1; i > r.value; i--)
      if (d[i]) begin
        s.next = 8'(i);
        s.found = 1'b1;
      end
    for (int i = 0; i < MaxDomain; i++)
      if (d[i]) s.tail = 8'(i);
    for (int i = MaxDomain - 1; i >= 0; i--)
      if (d[i]) s.head = 8'(i);
    s.nonempty = (d != '0);
    s.last = 1'b1;
    if (r.typed) begin
      s.count = r.count;
      s.assigned = r.assigned;
    end
    pending = {pending, s};
  endfunction

  task automatic send_request(request_t r);
    int gap;
    gap = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd <= r.cmd;
    var_id <= r.var_id;
    value <= r.value;
    word_index <= r.widx;
    word_data <= r.wdata;
    do @(posedge clk); while (!(start && !busy));
    apply_request(r);
  endtask

  task automatic write_trail_enable(logic en);
    @(negedge clk);
    start <= 1'b0;
    wait (pending.size() == 0);
    repeat (SettleCycles) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= en;
    @(negedge clk);
    cfg_we <= 1'b0;
    trail_on = en;
  endtask

  function automatic request_t random_request();
    request_t r;
    int pick;
    r = '{default: '0};
    pick = $urandom_range(0, 99);
    if (pick < 8) r.cmd = CmdInit;
    else if (pick < 35) r.cmd = CmdRemove;
    else if (pick < 60) r.cmd = CmdAdd;
    else if (pick < 70) r.cmd = CmdReduce;
    else if (pick < 82) r.cmd = CmdRestore;
    else if (pick < 94) r.cmd = CmdQuery;
    else r.cmd = ($urandom_range(0, 1) != 0) ? CmdSpare6 : CmdSpare7;
    // A few hot variables keep domains deep; the rest spread over all of them.
    r.var_id = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 5)) : 6'($urandom);
    r.value = ($urandom_range(0, 9) != 0) ? 9'($urandom_range(0, 255)) : 9'($urandom);
    r.widx = 2'($urandom);
    case ($urandom_range(0, 5))
      0: r.wdata = '0;
      1: r.wdata = '1;
      2: r.wdata = 64'd1 << $urandom_range(0, 63);
      default: r.wdata = {$urandom, $urandom};
    endcase
    return r;
  endfunction

  request_t directed [$];

  initial begin
    request_t r;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    cmd = CmdQuery;
    var_id = '0;
    value = '0;
    word_index = '0;
    word_data = '0;
    trail_on = 1'b1;
    for (int i = 0; i < NumVars; i++) begin
      domains[i] = '0;
      counts[i] = '0;
      assigned_q[i] = 1'b0;
    end
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed = '{
      '{CmdQuery,   6'd0,  9'd0,   2'd0, 64'd0,  1, 9'd0,   1'b0},
      '{CmdInit,    6'd1,  9'd256, 2'd0, 64'd0,  1, 9'd256, 1'b0},
      '{CmdInit,    6'd2,  9'd511, 2'd0, 64'd0,  1, 9'd256, 1'b0},
      '{CmdInit,    6'd3,  9'd0,   2'd0, 64'd0,  1, 9'd0,   1'b0},
      '{CmdRemove,  6'd1,  9'd0,   2'd0, 64'd0,  1, 9'd255, 1'b0},
      '{CmdRemove,  6'd1,  9'd255, 2'd0, 64'd0,  0, 9'd0,   1'b0},
      '{CmdRemove,  6'd3,  9'd7,   2'd0, 64'd0,  1, 9'd0,   1'b0},
      '{CmdAdd,     6'd3,  9'd255, 2'd0, 64'd0,  1, 9'd1,   1'b0},
      '{CmdAdd,     6'd2,  9'd5,   2'd0, 64'd0,  1, 9'd256, 1'b0},
      '{CmdAdd,     6'd1,  9'd256, 2'd0, 64'd0,  0, 9'd0,   1'b0},
      '{CmdRemove,  6'd3,  9'd300, 2'd0, 64'd0,  0, 9'd0,   1'b0},
      '{CmdReduce,  6'd2,  9'd511, 2'd0, 64'd0,  0, 9'd0,   1'b0},
      '{CmdReduce,  6'd1,  9'd128, 2'd0, 64'd0,  1, 9'd1,   1'b1},
      '{CmdReduce,  6'd4,  9'd63,  2'd0, 64'd0,  1, 9'd1,   1'b1},
      '{CmdRestore, 6'd5,  9'd0,   2'd3, '1,     1, 9'd64,  1'b0},
      '{CmdRestore, 6'd5,  9'd0,   2'd0, 64'd1,  1, 9'd65,  1'b0},
      '{CmdRestore, 6'd6,  9'd3,   2'd2, 64'd8,  1, 9'd1,   1'b1},
      '{CmdRestore, 6'd6,  9'd3,   2'd2, 64'd0,  1, 9'd0,   1'b0},
      '{CmdSpare6,  6'd2,  9'd64,  2'd0, 64'd0,  0, 9'd0,   1'b0},
      '{CmdSpare7,  6'd5,  9'd192, 2'd0, 64'd0,  0, 9'd0,   1'b0},
      '{CmdQuery,   6'd63, 9'd511, 2'd1, 64'd0,  1, 9'd0,   1'b0},
      '{CmdQuery,   6'd5,  9'd255, 2'd0, 64'd0,  0, 9'd0,   1'b0}
    };
    foreach (directed[i]) send_request(directed[i]);

    // Trail records off for a stretch of the directed cases too.
    write_trail_enable(1'b0);
    r = '{CmdReduce, 6'd2, 9'd0, 2'd0, 64'd0, 1, 9'd1, 1'b1};
    send_request(r);
    r = '{CmdRemove, 6'd2, 9'd0, 2'd0, 64'd0, 1, 9'd0, 1'b1};
    send_request(r);

    for (int phase = 0; phase < 4; phase++) begin
      write_trail_enable(phase[0] ? 1'b0 : 1'b1);
      for (int i = 0; i < 80; i++) send_request(random_request());
    end

    @(negedge clk);
    start <= 1'b0;
    wait (pending.size() == 0);
    repeat (SettleCycles) @(posedge clk);
    if (errors == 0) begin
      $display("bitset_domain_store regression: pass");
    end else begin
      $display("bitset_domain_store regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/bds_pkg.sv
hdl/bds_ram.sv
hdl/bitset_domain_store.sv
verif/tb_bitset_domain_store.sv
